FILE: rtl/core/iss_pkg.sv
// Shared types and constants for the indexed sequential search block.
`default_nettype none
package iss_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ECNT_W = 17;
  localparam int unsigned ICNT_W = 5;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [OP_W-1:0] OP_WRITE_DATA  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_INDEX = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_INDEX_COUNT = 1'b1;

  typedef struct packed {
    logic accept;
    logic idx_step;
    logic dat_from_cur;
    logic dat_from_prev;
    logic dat_step;
    logic res_miss;
    logic res_first;
    logic res_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ni_zero;
    logic idx_gt;
    logic i_zero;
    logic i_last;
    logic j_end;
    logic dat_gt;
    logic dat_eq;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/iss_if.sv
// Item channel interfaces for the query input and the result output.
`default_nettype none
interface iss_in_if;
  import iss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         data_address;
  logic [SLOT_W-1:0]        slot;
  logic [POS_W-1:0]         slot_position;
  logic signed [KEY_W-1:0]  value;

  modport source (output valid, opcode, data_address, slot, slot_position, value,
                  input ready);
  modport sink (input valid, opcode, data_address, slot, slot_position, value,
                output ready);
endinterface

interface iss_out_if;
  import iss_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/iss_ctrl.sv
// Controller state machine: index walk, data scan, result hand-off.
`default_nettype none
module iss_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [iss_pkg::OP_W-1:0] in_opcode,
  output logic                         in_ready,
  input  wire iss_pkg::sts_t           sts,
  output iss_pkg::cmd_t                cmd
);
  import iss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_IDX  = 4'b0010,
    S_DAT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_opcode == OP_QUERY) begin
          if (sts.ni_zero) begin
            cmd.res_miss = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_IDX;
          end
        end
      end
      S_IDX: begin
        if (sts.idx_gt) begin
          if (sts.i_last) begin
            cmd.dat_from_cur = 1'b1;
            state_nxt        = S_DAT;
          end else begin
            cmd.idx_step = 1'b1;
          end
        end else if (sts.i_zero) begin
          cmd.res_first = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.dat_from_prev = 1'b1;
          state_nxt         = S_DAT;
        end
      end
      S_DAT: begin
        if (sts.j_end) begin
          cmd.res_miss = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.dat_gt) begin
          cmd.dat_step = 1'b1;
        end else if (sts.dat_eq) begin
          cmd.res_hit = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.res_miss = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/iss_dp.sv
// Datapath: key stores, scan counters, key compares and result register.
`default_nettype none
module iss_dp #(
  parameter int unsigned DATA_DEPTH  = 65536,
  parameter int unsigned INDEX_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire iss_pkg::cmd_t                 cmd,
  input  wire logic [iss_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [iss_pkg::POS_W-1:0]     in_data_address,
  input  wire logic [iss_pkg::SLOT_W-1:0]    in_slot,
  input  wire logic [iss_pkg::POS_W-1:0]     in_slot_position,
  input  wire logic signed [iss_pkg::KEY_W-1:0] in_value,
  input  wire logic [iss_pkg::ECNT_W-1:0]    entry_count,
  input  wire logic [iss_pkg::ICNT_W-1:0]    index_count,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [iss_pkg::POS_W-1:0]          out_position,
  output iss_pkg::sts_t                      sts
);
  import iss_pkg::*;

  localparam int unsigned DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int unsigned NW  = $clog2(DATA_DEPTH + 1);
  localparam int unsigned NIW = $clog2(INDEX_DEPTH + 1);
  localparam int unsigned JW  = (NW > POS_W) ? NW : POS_W + 1;
  localparam int unsigned IW  = KEY_W + POS_W;

  logic signed [KEY_W-1:0] key_r;
  logic [NIW-1:0]          i_r, i_nxt;
  logic [JW-1:0]           j_r, j_nxt;
  logic [POS_W-1:0]        prev_pos_r;
  logic                    res_found_r;
  logic [POS_W-1:0]        res_pos_r;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [POS_W-1:0]        out_pos_r;

  logic [NIW-1:0]   ni;
  logic [NW-1:0]    n;
  logic             dat_we, idx_we;
  logic [IW-1:0]    idx_rd;
  logic [KEY_W-1:0] dat_rd;
  logic [KEY_W-1:0] idx_key;
  logic [POS_W-1:0] idx_pos;
  logic             idx_eq;

  assign ni = (32'(index_count) > INDEX_DEPTH) ? NIW'(INDEX_DEPTH) : NIW'(index_count);
  assign n  = (32'(entry_count) > DATA_DEPTH) ? NW'(DATA_DEPTH) : NW'(entry_count);

  assign dat_we = cmd.accept && in_opcode == OP_WRITE_DATA &&
                  32'(in_data_address) < DATA_DEPTH;
  assign idx_we = cmd.accept && in_opcode == OP_WRITE_INDEX &&
                  32'(in_slot) < INDEX_DEPTH;

  // read addresses follow the counters' next values so data lines up with i_r / j_r
  always_comb begin
    i_nxt = i_r;
    if (cmd.accept) begin
      i_nxt = '0;
    end else if (cmd.idx_step) begin
      i_nxt = i_r + NIW'(1);
    end
  end

  always_comb begin
    j_nxt = j_r;
    if (cmd.dat_from_cur) begin
      j_nxt = JW'(idx_pos);
    end else if (cmd.dat_from_prev) begin
      j_nxt = JW'(prev_pos_r);
    end else if (cmd.dat_step) begin
      j_nxt = j_r + JW'(1);
    end
  end

  iss_ram #(.WIDTH(KEY_W), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (DAW'(in_data_address)),
    .wdata (in_value),
    .raddr (j_nxt[DAW-1:0]),
    .rdata (dat_rd)
  );

  iss_ram #(.WIDTH(IW), .DEPTH(INDEX_DEPTH)) u_index_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (IAW'(in_slot)),
    .wdata ({in_slot_position, in_value}),
    .raddr (i_nxt[IAW-1:0]),
    .rdata (idx_rd)
  );

  assign idx_key = idx_rd[KEY_W-1:0];
  assign idx_pos = idx_rd[IW-1:KEY_W];
  assign idx_eq  = key_r == $signed(idx_key);

  always_comb begin
    sts.ni_zero  = ni == '0;
    sts.idx_gt   = key_r > $signed(idx_key);
    sts.i_zero   = i_r == '0;
    sts.i_last   = (i_r + NIW'(1)) == ni;
    sts.j_end    = j_r >= JW'(n);
    sts.dat_gt   = key_r > $signed(dat_rd);
    sts.dat_eq   = key_r == $signed(dat_rd);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (cmd.accept) begin
      key_r <= in_value;
    end
    if (cmd.idx_step) begin
      prev_pos_r <= idx_pos;
    end
    if (cmd.res_miss) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end else if (cmd.res_first) begin
      res_found_r <= idx_eq;
      res_pos_r   <= idx_eq ? idx_pos : '0;
    end else if (cmd.res_hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= j_r[POS_W-1:0];
    end
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_pos_r   <= res_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule
`default_nettype wire

FILE: rtl/core/indexed_sequential_search.sv
// Indexed sequential search top level: config registers, controller and datapath.
// Writes (opcodes 0 and 1) are done on acceptance; an unused opcode is dropped.
// A query runs k index compares (0 with an empty index, else 1..INDEX_DEPTH), then
// m data compares (0..segment length + 1), then the load of the output register.
// One item is worked at a time; the single data-store read port, one compare per
// cycle, sets the rate while the output is not stalled. Reset (rst_n, synchronous)
// clears the control state and both count registers; key stores are not cleared
// and hold garbage until written.
`default_nettype none
module indexed_sequential_search #(
  parameter int unsigned DATA_DEPTH  = 65536,
  parameter int unsigned INDEX_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  iss_in_if.sink                              in_if,
  iss_out_if.source                           out_if,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [iss_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [iss_pkg::PDATA_W-1:0]    pwdata,
  output logic      [iss_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);
  import iss_pkg::*;

  logic [ECNT_W-1:0] entry_count_r;
  logic [ICNT_W-1:0] index_count_r;
  logic              cfg_we;
  logic              in_ready;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      index_count_r <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ENTRY_COUNT: entry_count_r <= pwdata[ECNT_W-1:0];
        REG_INDEX_COUNT: index_count_r <= pwdata[ICNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENTRY_COUNT: prdata = PDATA_W'(entry_count_r);
      REG_INDEX_COUNT: prdata = PDATA_W'(index_count_r);
      default:         prdata = '0;
    endcase
  end

  iss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign in_if.ready = in_ready;

  iss_dp #(.DATA_DEPTH(DATA_DEPTH), .INDEX_DEPTH(INDEX_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_if.opcode),
    .in_data_address  (in_if.data_address),
    .in_slot          (in_if.slot),
    .in_slot_position (in_if.slot_position),
    .in_value         (in_if.value),
    .entry_count      (entry_count_r),
    .index_count      (index_count_r),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_found        (out_if.found),
    .out_position     (out_if.position),
    .sts              (sts)
  );

endmodule
`default_nettype wire

FILE: rtl/core/iss_chk.sv
// Port-level assertion checker for the indexed sequential search block, with bind.
`default_nettype none
module iss_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_found,
  input wire logic [iss_pkg::POS_W-1:0]   out_position,
  input wire logic                        pready
);
  import iss_pkg::*;

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a miss always reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss with nonzero position");

  // no item, query or not, produces a result on the very next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind indexed_sequential_search iss_chk u_iss_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_found    (out_if.found),
  .out_position (out_if.position),
  .pready       (pready)
);
`default_nettype wire
